/* design/bta_pkg.sv */
// ----------------------------------------------------------------------------
// bta_pkg
// types, constants and helpers shared by the boundary tag allocator
// ----------------------------------------------------------------------------
package bta_pkg;

  localparam int MEM_WORDS   = 4096;
  localparam int ADDR_W      = $clog2(MEM_WORDS);
  localparam int WORD_W      = 16;
  localparam int CNT_W       = 13;
  localparam int BLOCK_LIMIT = 256;
  localparam int OVERHEAD    = 4;
  localparam int DATA_OFFSET = 3;
  localparam int INIT_COUNT  = MEM_WORDS / BLOCK_LIMIT;
  localparam int INIT_W      = $clog2(INIT_COUNT + 1);
  localparam int VISIT_W     = $clog2(MEM_WORDS + 1);
  localparam int SUM_W       = WORD_W + 2;

  localparam logic [ADDR_W-1:0] A_ONE      = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] A_TWO      = ADDR_W'(2);
  localparam logic [ADDR_W-1:0] A_OFS      = ADDR_W'(DATA_OFFSET);
  localparam logic [ADDR_W-1:0] A_OVH      = ADDR_W'(OVERHEAD);
  localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(MEM_WORDS - 1);
  localparam logic [ADDR_W-1:0] INIT_TOP   = ADDR_W'(MEM_WORDS - BLOCK_LIMIT);
  localparam logic [ADDR_W-1:0] INIT_STEP  = ADDR_W'(BLOCK_LIMIT - 1);
  localparam logic [WORD_W-1:0] INIT_SIZE  = WORD_W'(BLOCK_LIMIT - 1 - OVERHEAD);
  localparam logic [WORD_W-1:0] W_LIMIT    = WORD_W'(BLOCK_LIMIT);
  localparam logic [SUM_W-1:0]  S_LIMIT    = SUM_W'(BLOCK_LIMIT);
  localparam logic [SUM_W-1:0]  S_OVH      = SUM_W'(OVERHEAD);
  localparam logic [SUM_W-1:0]  NA_MAX     = SUM_W'(MEM_WORDS - 1 - OVERHEAD);
  localparam logic [VISIT_W-1:0] VISIT_MAX = VISIT_W'(MEM_WORDS);
  localparam logic [INIT_W-1:0] INIT_LAST  = INIT_W'(INIT_COUNT);

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] request_words;
    logic [11:0] block_addr;
  } bta_req_t;

  typedef struct packed {
    logic [11:0] result_addr;
    logic        status;
    logic [12:0] free_blocks;
    logic [12:0] free_words;
  } bta_rsp_t;

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE,
    S_A_RSZ, S_A_SZ, S_A_NXT,
    S_A_X_N, S_A_X_P, S_A_X_WP, S_A_X_WN, S_A_X_RS, S_A_X_WT,
    S_A_W1, S_A_W2, S_A_W3, S_A_W4,
    S_F_RORIG, S_F_ORIG, S_F_PT, S_F_PSZ, S_F_PTAG, S_F_PW1, S_F_PW2,
    S_F_NA, S_F_NSZ, S_F_NTAG,
    S_F_U_N, S_F_U_P, S_F_U_WP, S_F_U_WN, S_F_NW1, S_F_NW2,
    S_F_H1, S_F_H2, S_F_H3, S_F_H4, S_F_H5,
    S_F_END, S_CARVE, S_CARVE2, S_DONE
  } bta_state_t;

  // status word of a free block
  function automatic logic is_free_tag(input logic [WORD_W-1:0] t);
    return (t != '0) && (t < W_LIMIT);
  endfunction

endpackage

/* design/bta_ram.sv */
// ----------------------------------------------------------------------------
// bta_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bta_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/bta_out_buf.sv */
// ----------------------------------------------------------------------------
// bta_out_buf
// result register holding one response transaction until taken
// ----------------------------------------------------------------------------
module bta_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  bta_pkg::bta_rsp_t  data,
  output logic               valid,
  input  logic               stall,
  output bta_pkg::bta_rsp_t  q
);
  import bta_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= data;
    end
  end

endmodule

/* design/boundary_tag_heap_allocator.sv */
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator
// first-fit boundary-tag heap allocator over a 4096 x 16 word memory
// ----------------------------------------------------------------------------
// One request transaction is worked at a time by a sequencer that reads,
// modifies and writes back the heap memory, whose read data is
// registered. After reset a clearing pass zeroes all 4096 words of the
// heap; no request is taken during it. An allocate walks the free list
// from its head until a block fits exactly or can be split; a free
// inspects the lower and upper neighbours and merges those that are
// free; an initialise runs the same clearing pass and then carves the
// heap into its maximal free blocks. A new request is taken while the
// previous response still waits in the output register.
module boundary_tag_heap_allocator (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  bta_pkg::bta_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output bta_pkg::bta_rsp_t rsp
);
  import bta_pkg::*;

  bta_state_t state, state_next;

  // heap memory port
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [WORD_W-1:0] wdata, rdata;

  // sequencer registers
  logic [ADDR_W-1:0]  head, b, nb, pb, lp, ln, clr, init_a, res, n_req;
  logic [WORD_W-1:0]  cur, orig, s_rem, sz;
  logic [CNT_W-1:0]   bcnt, wcnt;
  logic [VISIT_W-1:0] visits;
  logic [1:0]         joins;
  logic [INIT_W-1:0]  init_i;
  logic               init_mode, st;

  logic     accept, load;
  bta_rsp_t rsp_d;

  // values derived from the word just read
  logic [ADDR_W-1:0] rd_addr, pb_c;
  logic              rd_free, exact, split_fit, joinable, na_out;
  logic [WORD_W:0]   need;
  logic [WORD_W-1:0] s_rem_c;
  logic [SUM_W-1:0]  js_c, na_c;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign load      = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  assign rd_addr   = rdata[ADDR_W-1:0];
  assign rd_free   = is_free_tag(rdata);
  assign need      = (WORD_W+1)'(n_req) + (WORD_W+1)'(OVERHEAD);
  assign exact     = (rdata == WORD_W'(n_req));
  assign split_fit = ({1'b0, rdata} > need);
  assign s_rem_c   = rdata - need[WORD_W-1:0];
  // previous neighbour from the status word just below the block
  assign pb_c      = b - rd_addr - A_OVH;
  // joined size with the neighbour whose size sits in sz
  assign js_c      = SUM_W'(cur) + SUM_W'(sz) + S_OVH;
  assign joinable  = (js_c < S_LIMIT);
  // next neighbour, no wrap, past top counts as not free
  assign na_c      = SUM_W'(b) + SUM_W'(cur) + S_OVH;
  assign na_out    = (na_c > NA_MAX);

  bta_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_heap (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:   if (clr == CLEAR_LAST) begin
                   state_next = init_mode ? S_CARVE : S_IDLE;
                 end
      S_IDLE:    if (accept) begin
                   case (req.cmd)
                     CMD_ALLOC: state_next = (head == '0) ? S_DONE : S_A_RSZ;
                     CMD_FREE:  state_next = S_F_RORIG;
                     CMD_INIT:  state_next = S_CLEAR;
                     default:   state_next = S_DONE;
                   endcase
                 end
      S_A_RSZ:   state_next = S_A_SZ;
      S_A_SZ:    begin
                   if (exact) begin
                     state_next = S_A_X_N;
                   end else if (split_fit) begin
                     state_next = S_A_W1;
                   end else begin
                     state_next = S_A_NXT;
                   end
                 end
      S_A_NXT:   state_next = (rd_addr == '0 || visits == VISIT_MAX) ? S_DONE : S_A_SZ;
      S_A_X_N:   state_next = S_A_X_P;
      S_A_X_P:   state_next = S_A_X_WP;
      S_A_X_WP:  state_next = S_A_X_WN;
      S_A_X_WN:  state_next = S_A_X_RS;
      S_A_X_RS:  state_next = S_A_X_WT;
      S_A_X_WT:  state_next = S_DONE;
      S_A_W1:    state_next = S_A_W2;
      S_A_W2:    state_next = S_A_W3;
      S_A_W3:    state_next = S_A_W4;
      S_A_W4:    state_next = S_DONE;
      S_F_RORIG: state_next = S_F_ORIG;
      S_F_ORIG:  state_next = S_F_PT;
      S_F_PT:    state_next = (rd_free && pb_c != '0) ? S_F_PSZ : S_F_NA;
      S_F_PSZ:   state_next = S_F_PTAG;
      S_F_PTAG:  state_next = (rd_free && joinable) ? S_F_PW1 : S_F_NA;
      S_F_PW1:   state_next = S_F_PW2;
      S_F_PW2:   state_next = S_F_NA;
      S_F_NA:    begin
                   if (!na_out) begin
                     state_next = S_F_NSZ;
                   end else begin
                     state_next = (joins == '0) ? S_F_H1 : S_F_END;
                   end
                 end
      S_F_NSZ:   state_next = S_F_NTAG;
      S_F_NTAG:  begin
                   if (rd_free && joinable) begin
                     state_next = S_F_U_N;
                   end else begin
                     state_next = (joins == '0) ? S_F_H1 : S_F_END;
                   end
                 end
      S_F_U_N:   state_next = S_F_U_P;
      S_F_U_P:   state_next = S_F_U_WP;
      S_F_U_WP:  state_next = S_F_U_WN;
      S_F_U_WN:  state_next = S_F_NW1;
      S_F_NW1:   state_next = S_F_NW2;
      S_F_NW2:   state_next = S_F_END;
      S_F_H1:    state_next = S_F_H2;
      S_F_H2:    state_next = S_F_H3;
      S_F_H3:    state_next = S_F_H4;
      S_F_H4:    state_next = S_F_H5;
      S_F_H5:    state_next = S_F_END;
      S_F_END:   state_next = init_mode ? S_CARVE : S_DONE;
      S_CARVE:   state_next = (init_i == INIT_LAST) ? S_DONE : S_CARVE2;
      S_CARVE2:  state_next = S_F_RORIG;
      S_DONE:    if (load) begin
                   state_next = S_IDLE;
                 end
      default:   state_next = S_IDLE;
    endcase
  end

  // memory accesses issued by each step
  always_comb begin
    we    = 1'b0;
    waddr = b;
    wdata = '0;
    raddr = b;
    case (state)
      S_CLEAR:   begin we = 1'b1; waddr = clr; end
      S_A_SZ:    raddr = b + A_ONE;
      S_A_NXT:   raddr = rd_addr;
      S_A_X_N:   raddr = b + A_TWO;
      S_A_X_WP:  begin we = (lp != '0); waddr = lp + A_ONE; wdata = WORD_W'(ln); end
      S_A_X_WN:  begin we = (ln != '0); waddr = ln + A_TWO; wdata = WORD_W'(lp); end
      S_A_X_WT:  begin we = 1'b1; waddr = b + A_OFS + rd_addr; end
      S_A_W1:    begin we = 1'b1; wdata = s_rem; end
      S_A_W2:    begin
                   we = 1'b1; waddr = b + A_OFS + s_rem[ADDR_W-1:0]; wdata = s_rem;
                 end
      S_A_W3:    begin we = 1'b1; waddr = nb; wdata = WORD_W'(n_req); end
      S_A_W4:    begin we = 1'b1; waddr = nb + A_OFS + n_req; end
      S_F_ORIG:  raddr = b - A_ONE;
      S_F_PT:    raddr = pb_c;
      S_F_PSZ:   raddr = pb + A_OFS + rd_addr;
      S_F_PW1,
      S_F_NW1:   begin we = 1'b1; wdata = cur; end
      S_F_PW2,
      S_F_NW2:   begin we = 1'b1; waddr = b + A_OFS + cur[ADDR_W-1:0]; wdata = cur; end
      S_F_NA:    raddr = na_c[ADDR_W-1:0];
      S_F_NSZ:   raddr = nb + A_OFS + rd_addr;
      S_F_NTAG:  raddr = nb + A_ONE;
      S_F_U_N:   raddr = nb + A_TWO;
      S_F_U_WP:  begin we = (lp != '0); waddr = lp + A_ONE; wdata = WORD_W'(ln); end
      S_F_U_WN:  begin we = (ln != '0); waddr = ln + A_TWO; wdata = WORD_W'(lp); end
      S_F_H1:    begin we = (head != '0); waddr = head + A_TWO; wdata = WORD_W'(b); end
      S_F_H2:    begin we = 1'b1; waddr = b + A_ONE; wdata = WORD_W'(head); end
      S_F_H3:    begin we = 1'b1; waddr = b + A_TWO; end
      S_F_H5:    begin we = 1'b1; waddr = b + A_OFS + rd_addr; wdata = rdata; end
      S_CARVE:   begin
                   we = (init_i != INIT_LAST); waddr = init_a; wdata = INIT_SIZE;
                 end
      S_CARVE2:  begin
                   we = 1'b1; waddr = init_a + A_OFS + INIT_SIZE[ADDR_W-1:0];
                   wdata = INIT_SIZE;
                 end
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      bcnt      <= '0;
      wcnt      <= '0;
      clr       <= '0;
      init_mode <= 1'b0;
    end else begin
      case (state)
        S_CLEAR:  clr <= clr + A_ONE;
        S_IDLE:   if (accept && req.cmd == CMD_INIT) begin
                    head      <= '0;
                    bcnt      <= '0;
                    wcnt      <= '0;
                    clr       <= '0;
                    init_mode <= 1'b1;
                  end
        S_A_X_P:  if (head == b) head <= ln;
        S_A_X_WT: begin
                    bcnt <= bcnt - CNT_W'(1);
                    wcnt <= wcnt - orig[CNT_W-1:0];
                  end
        S_A_W4:   wcnt <= wcnt - CNT_W'(n_req) - CNT_W'(OVERHEAD);
        S_F_U_P:  if (head == nb) head <= ln;
        S_F_H5:   head <= b;
        S_F_END:  begin
                    bcnt <= bcnt + CNT_W'(1) - CNT_W'(joins);
                    wcnt <= wcnt + orig[CNT_W-1:0] + CNT_W'({joins, 2'b00});
                  end
        S_DONE:   if (load) init_mode <= 1'b0;
        default:  ;
      endcase
    end
  end

  // working registers of the current transaction
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE:    if (accept) begin
                   n_req  <= req.request_words;
                   res    <= '0;
                   st     <= (req.cmd == CMD_ALLOC) && (head == '0);
                   visits <= '0;
                   b      <= (req.cmd == CMD_ALLOC) ? head : req.block_addr - A_OFS;
                   init_i <= '0;
                   init_a <= INIT_TOP;
                 end
      S_A_RSZ:   visits <= visits + VISIT_W'(1);
      S_A_SZ:    begin
                   orig  <= rdata;
                   s_rem <= s_rem_c;
                   nb    <= b + s_rem_c[ADDR_W-1:0] + A_OVH;
                 end
      S_A_NXT:   begin
                   b <= rd_addr;
                   if (rd_addr == '0 || visits == VISIT_MAX) begin
                     st <= 1'b1;
                   end else begin
                     visits <= visits + VISIT_W'(1);
                   end
                 end
      S_A_X_N:   ln <= rd_addr;
      S_A_X_P:   lp <= rd_addr;
      S_A_X_WT:  res <= b + A_OFS;
      S_A_W4:    res <= nb + A_OFS;
      S_F_ORIG:  begin
                   orig  <= rdata;
                   cur   <= rdata;
                   joins <= '0;
                 end
      S_F_PT:    pb <= pb_c;
      S_F_PSZ:   sz <= rdata;
      S_F_PTAG:  if (rd_free && joinable) begin
                   b   <= pb;
                   cur <= js_c[WORD_W-1:0];
                 end
      S_F_PW2:   joins <= joins + 2'd1;
      S_F_NA:    nb <= na_c[ADDR_W-1:0];
      S_F_NSZ:   sz <= rdata;
      S_F_NTAG:  if (rd_free && joinable) cur <= js_c[WORD_W-1:0];
      S_F_U_N:   ln <= rd_addr;
      S_F_U_P:   lp <= rd_addr;
      S_F_NW2:   joins <= joins + 2'd1;
      S_F_END:   if (init_mode) begin
                   init_a <= init_a - INIT_STEP;
                   init_i <= init_i + INIT_W'(1);
                 end
      S_CARVE2:  b <= init_a;
      default:   ;
    endcase
  end

  // response transaction
  always_comb begin
    rsp_d.result_addr = res;
    rsp_d.status      = st;
    rsp_d.free_blocks = bcnt;
    rsp_d.free_words  = wcnt;
  end

  bta_out_buf u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .data  (rsp_d),
    .valid (rsp_valid),
    .stall (rsp_stall),
    .q     (rsp)
  );

  // a failed allocate never reports an address
  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status |-> rsp.result_addr == '0)
    else $error("failed allocate reports an address");

  // reset always starts the clearing pass from the bottom
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (state == S_CLEAR) && (clr == '0))
    else $error("reset did not start heap clearing");

  // a block is pushed on the list only when nothing was merged
  a_push_no_join: assert property (@(posedge clk) disable iff (rst)
    (state == S_F_H1) |-> (joins == '0))
    else $error("merged block pushed on free list");

  // no request is taken while the sequencer is busy
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> req_stall)
    else $error("request taken while busy");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the boundary tag heap allocator against a built-in heap predictor
// ----------------------------------------------------------------------------
// A directed table covers the empty heap, initialise, exact fits, splits,
// merges, bad frees and the unused command. Random traffic follows, mostly
// allocate and free of live blocks with occasional noise and reinitialise.
// Every response transaction is compared with the oldest prediction.
module testbench;
  import bta_pkg::*;

  localparam int MW = MEM_WORDS;
  localparam int CNT_MASK = (1 << CNT_W) - 1;
  localparam int RAND_ITEMS = 650;
  localparam int QUIET_LIMIT = 40000;
  localparam int HOLD_CYCLES = 400;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_stall;
  bta_req_t req;
  logic     rsp_valid;
  logic     rsp_stall;
  bta_rsp_t rsp;

  boundary_tag_heap_allocator dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  // ---------------------------------------------------------------- predictor
  // shadow copy of the heap and its bookkeeping
  logic [15:0] heap_mem [MW];
  int unsigned list_top;
  int unsigned blk_cnt;
  int unsigned wrd_cnt;

  function automatic int unsigned wrap_add(int unsigned a, int unsigned d);
    return (a % MW + d % MW) % MW;
  endfunction

  function automatic int unsigned wrap_sub(int unsigned a, int unsigned d);
    return (a % MW + MW - d % MW) % MW;
  endfunction

  function automatic int unsigned mem_rd(int unsigned a);
    return heap_mem[a % MW];
  endfunction

  function automatic void mem_wr(int unsigned a, int unsigned v);
    heap_mem[a % MW] = v[15:0];
  endfunction

  function automatic int unsigned link_next(int unsigned b);
    return mem_rd(wrap_add(b, 1)) % MW;
  endfunction

  function automatic int unsigned link_prev(int unsigned b);
    return mem_rd(wrap_add(b, 2)) % MW;
  endfunction

  // status word sits just past the payload
  function automatic int unsigned tag_addr(int unsigned b);
    return wrap_add(wrap_add(b, DATA_OFFSET), mem_rd(b));
  endfunction

  function automatic void put_size(int unsigned b, int unsigned s);
    mem_wr(b, s);
    mem_wr(tag_addr(b), s);
  endfunction

  function automatic bit free_status(int unsigned t);
    return t > 0 && t < BLOCK_LIMIT;
  endfunction

  function automatic bit block_free(int unsigned b);
    if (b == 0) return 0;
    return free_status(mem_rd(tag_addr(b)));
  endfunction

  function automatic void unlink_node(int unsigned b);
    int unsigned p;
    int unsigned n;
    p = link_prev(b);
    n = link_next(b);
    if (list_top == b) list_top = n;
    if (p != 0) mem_wr(wrap_add(p, 1), n);
    if (n != 0) mem_wr(wrap_add(n, 2), p);
  endfunction

  // give a block back, merging with free neighbours when the sum stays small
  function automatic void give_back(int unsigned b);
    int unsigned orig;
    int unsigned joins;
    int unsigned pb;
    int unsigned nb;
    int unsigned t;
    int unsigned js;
    orig = mem_rd(b);
    joins = 0;
    t = mem_rd(wrap_sub(b, 1));
    pb = free_status(t) ? wrap_sub(b, t + OVERHEAD) : 0;
    if (block_free(pb)) begin
      js = mem_rd(b) + mem_rd(pb) + OVERHEAD;
      if (js < BLOCK_LIMIT) begin
        b = pb;
        put_size(b, js);
        joins++;
      end
    end
    // upper neighbour, no wrap past the top of the heap
    nb = b % MW + mem_rd(b) + OVERHEAD;
    if (nb > MW - 1 - OVERHEAD || !block_free(nb)) nb = 0;
    if (block_free(nb)) begin
      js = mem_rd(b) + mem_rd(nb) + OVERHEAD;
      if (js < BLOCK_LIMIT) begin
        unlink_node(nb);
        put_size(b, js);
        joins++;
      end
    end
    if (joins == 0) begin
      if (list_top != 0) mem_wr(wrap_add(list_top, 2), b);
      mem_wr(wrap_add(b, 1), list_top);
      mem_wr(wrap_add(b, 2), 0);
      mem_wr(tag_addr(b), mem_rd(b));
      list_top = b;
    end
    blk_cnt = (blk_cnt + 1 - joins) & CNT_MASK;
    wrd_cnt = (wrd_cnt + orig + joins * OVERHEAD) & CNT_MASK;
  endfunction

  // first fit walk; returns data address, 0 when nothing fits
  function automatic int unsigned take_block(int unsigned n, output bit hit);
    int unsigned b;
    int unsigned visits;
    int unsigned s;
    int unsigned nb;
    b = list_top;
    visits = 0;
    hit = 0;
    while (b != 0 && visits < MW) begin
      s = mem_rd(b);
      visits++;
      if (s == n) begin
        unlink_node(b);
        blk_cnt = (blk_cnt - 1) & CNT_MASK;
        wrd_cnt = (wrd_cnt - s) & CNT_MASK;
        mem_wr(tag_addr(b), 0);
        hit = 1;
        return wrap_add(b, DATA_OFFSET);
      end
      if (s > n + OVERHEAD) begin
        s -= n + OVERHEAD;
        put_size(b, s);
        nb = wrap_add(b, s + OVERHEAD);
        put_size(nb, n);
        mem_wr(tag_addr(nb), 0);
        wrd_cnt = (wrd_cnt - (n + OVERHEAD)) & CNT_MASK;
        hit = 1;
        return wrap_add(nb, DATA_OFFSET);
      end
      b = link_next(b);
    end
    return 0;
  endfunction

  function automatic void wipe_heap();
    foreach (heap_mem[i]) heap_mem[i] = '0;
    list_top = 0;
    blk_cnt = 0;
    wrd_cnt = 0;
  endfunction

  function automatic bta_rsp_t predict_heap(bta_req_t r);
    bta_rsp_t o;
    bit hit;
    int unsigned a;
    o = '0;
    case (r.cmd)
      CMD_ALLOC: begin
        o.result_addr = 12'(take_block(r.request_words, hit));
        if (!hit) begin
          o.result_addr = '0;
          o.status = 1'b1;
        end
      end
      CMD_FREE: give_back(wrap_sub(r.block_addr, DATA_OFFSET));
      CMD_INIT: begin
        wipe_heap();
        a = MW - BLOCK_LIMIT;
        for (int i = 0; i < MW / BLOCK_LIMIT; i++) begin
          put_size(a, BLOCK_LIMIT - 1 - OVERHEAD);
          give_back(a);
          a -= BLOCK_LIMIT - 1;
        end
      end
      default: ;
    endcase
    o.free_blocks = 13'(blk_cnt);
    o.free_words = 13'(wrd_cnt);
    return o;
  endfunction

  // ---------------------------------------------------------------- shared state
  bta_rsp_t expected_rsp_q[$];
  int unsigned live_addrs[$];
  int errors = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  bit start_hold = 0;
  bit stim_done = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- sender
  // one request transaction per call; predicts it at the moment it is offered
  task automatic send_req(input logic [1:0] c, input logic [11:0] n,
                          input logic [11:0] a, input bit typed,
                          input bta_rsp_t typed_rsp);
    bta_req_t r;
    bta_rsp_t p;
    r.cmd = c;
    r.request_words = n;
    r.block_addr = a;
    p = predict_heap(r);
    expected_rsp_q.push_back(typed ? typed_rsp : p);
    if (c == CMD_ALLOC && p.status == 1'b0) live_addrs.push_back(p.result_addr);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        req_valid <= 1'b0;
        req <= bta_req_t'($urandom);
      end
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
  endtask

  typedef struct {
    logic [1:0]  c;
    logic [11:0] n;
    logic [11:0] a;
    int          pick;   // 0 literal address, else n-th latest live block
    bit          typed;
    bta_rsp_t    want;
  } dir_row_t;

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    int unsigned k;
    int unsigned sel;
    int unsigned adr;
    bit init_due;

    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    wipe_heap();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    rows = '{
      '{CMD_NOP,   12'd0,    12'd0,    0, 1, '{12'd0, 1'b0, 13'd0, 13'd0}},
      '{CMD_ALLOC, 12'd0,    12'd0,    0, 1, '{12'd0, 1'b1, 13'd0, 13'd0}},
      '{CMD_ALLOC, 12'hfff,  12'd0,    0, 1, '{12'd0, 1'b1, 13'd0, 13'd0}},
      '{CMD_FREE,  12'd0,    12'hfff,  0, 0, '0},   // free on a zeroed heap
      '{CMD_INIT,  12'hfff,  12'hfff,  0, 1, '{12'd0, 1'b0, 13'd16, 13'd4016}},
      '{CMD_ALLOC, 12'd251,  12'd0,    0, 0, '0},   // exact fit
      '{CMD_ALLOC, 12'd247,  12'd0,    0, 0, '0},   // bigger by overhead only
      '{CMD_ALLOC, 12'd0,    12'd0,    0, 0, '0},   // split, empty payload
      '{CMD_ALLOC, 12'hfff,  12'd0,    0, 0, '0},   // no fit on full list
      '{CMD_ALLOC, 12'd1,    12'd0,    0, 0, '0},
      '{CMD_FREE,  12'd0,    12'd0,    1, 0, '0},   // merges back into its donor
      '{CMD_ALLOC, 12'd100,  12'd0,    0, 0, '0},
      '{CMD_ALLOC, 12'd100,  12'd0,    0, 0, '0},
      '{CMD_ALLOC, 12'd40,   12'd0,    0, 0, '0},
      '{CMD_FREE,  12'd0,    12'd0,    2, 0, '0},   // lower neighbour allocated
      '{CMD_FREE,  12'd0,    12'd0,    2, 0, '0},   // both neighbours free
      '{CMD_FREE,  12'd0,    12'd0,    1, 0, '0},   // join would reach the limit
      '{CMD_NOP,   12'hfff,  12'hfff,  0, 0, '0},
      '{CMD_FREE,  12'd0,    12'd0,    0, 0, '0},   // bad free, wraps below zero
      '{CMD_FREE,  12'd0,    12'hfff,  0, 0, '0},   // bad free near the top
      '{CMD_INIT,  12'd0,    12'd0,    0, 1, '{12'd0, 1'b0, 13'd16, 13'd4016}}
    };
    foreach (rows[i]) begin
      row = rows[i];
      adr = row.a;
      if (row.pick > 0 && live_addrs.size() >= row.pick) begin
        sel = live_addrs.size() - row.pick;
        adr = live_addrs[sel];
        live_addrs.delete(sel);
      end
      if (row.c == CMD_INIT) live_addrs.delete();
      send_req(row.c, row.n, adr[11:0], row.typed, row.want);
    end

    // random traffic in three idling phases
    init_due = 0;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 3) begin
        sender_idle_pct = 47;
        stall_pct = 17;
      end else if (i == 2 * RAND_ITEMS / 3) begin
        sender_idle_pct = 0;
        stall_pct = 0;
        start_hold = 1;
      end else if (i == 0) begin
        sender_idle_pct = 17;
        stall_pct = 47;
      end
      k = $urandom_range(99);
      if (init_due && k < 30 || k < 2) begin
        live_addrs.delete();
        init_due = 0;
        send_req(CMD_INIT, 12'($urandom), 12'($urandom), 0, '0);
      end else if (k < 5) begin
        send_req(CMD_NOP, 12'($urandom), 12'($urandom), 0, '0);
      end else if (k < 8) begin
        // corrupting free, reinitialise shortly after
        init_due = 1;
        send_req(CMD_FREE, 12'($urandom), 12'($urandom), 0, '0);
      end else if (k < 55 || live_addrs.size() == 0) begin
        sel = $urandom_range(99);
        if (sel < 75) adr = $urandom_range(0, 60);
        else if (sel < 95) adr = $urandom_range(61, 251);
        else adr = $urandom_range(0, 4095);
        send_req(CMD_ALLOC, adr[11:0], 12'($urandom), 0, '0);
      end else begin
        sel = $urandom_range(live_addrs.size() - 1);
        adr = live_addrs[sel];
        live_addrs.delete(sel);
        send_req(CMD_FREE, 12'($urandom), adr[11:0], 0, '0);
      end
    end
    @(negedge clk);
    req_valid <= 1'b0;

    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    stim_done = 1;
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------- receiver
  // random stall, plus one long hold so the block backs up into its input
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 0;
    forever begin
      @(negedge clk);
      if (start_hold && !held) begin
        held = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    bta_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp_q.size() == 0) begin
        $error("response transaction with nothing expected");
        errors++;
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp.result_addr !== want.result_addr) begin
          $error("result_addr expected %0d got %0d", want.result_addr, rsp.result_addr);
          errors++;
        end
        if (rsp.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, rsp.status);
          errors++;
        end
        if (rsp.free_blocks !== want.free_blocks) begin
          $error("free_blocks expected %0d got %0d", want.free_blocks, rsp.free_blocks);
          errors++;
        end
        if (rsp.free_words !== want.free_words) begin
          $error("free_words expected %0d got %0d", want.free_words, rsp.free_words);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  // covers the clearing pass and the longest list walk several times over
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT && !stim_done) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule
